/* sv/apt_pkg.sv */
package apt_pkg;

  localparam int COORD_BITS   = 24;
  localparam int COEFF_BITS   = 16;
  localparam int NUM_AXES     = 3;
  localparam int ROW_BITS     = COEFF_BITS * NUM_AXES;
  localparam int VEC_BITS     = COORD_BITS + 1;
  localparam int PROD_BITS    = COEFF_BITS + VEC_BITS;
  localparam int ACC_BITS     = PROD_BITS + 2;
  localparam int RES_BITS     = ACC_BITS + 1;

  localparam int NUM_REGS      = 6;
  localparam int APB_DATA_BITS = 64;
  localparam int APB_ADDR_BITS = $clog2(8 * NUM_REGS);
  localparam int REG_IDX_BITS  = APB_ADDR_BITS - 3;

  localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  localparam logic [COEFF_BITS-1:0] COEFF_ONE = COEFF_BITS'(16'h4000);

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_ROW0    = 3'd0,
    REG_ROW1    = 3'd1,
    REG_ROW2    = 3'd2,
    REG_SHIFT_X = 3'd3,
    REG_SHIFT_Y = 3'd4,
    REG_SHIFT_Z = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic                   action;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
  } point_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic signed [COORD_BITS-1:0] out_z;
    logic                   saturated;
  } result_t;

  typedef struct packed {
    logic [NUM_AXES-1:0][ROW_BITS-1:0]   row;
    logic [NUM_AXES-1:0][COORD_BITS-1:0] shift;
  } cfg_t;

  // after operand prep
  typedef struct packed {
    logic                              valid;
    logic                              inverse;
    logic [NUM_AXES-1:0][VEC_BITS-1:0] vec;
  } stage1_t;

  // after the dot products
  typedef struct packed {
    logic                              valid;
    logic                              inverse;
    logic [NUM_AXES-1:0][ACC_BITS-1:0] acc;
  } stage3_t;

  function automatic logic signed [COEFF_BITS-1:0] coeff(
    input logic [NUM_AXES-1:0][ROW_BITS-1:0] row,
    input int unsigned                       i,
    input int unsigned                       j
  );
    return $signed(row[i][COEFF_BITS*j +: COEFF_BITS]);
  endfunction

endpackage

/* sv/apt_cfg_regs.sv */
module apt_cfg_regs
  import apt_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output cfg_t                     cfg_o
);

  logic [NUM_AXES-1:0][ROW_BITS-1:0]   row_q;
  logic [NUM_AXES-1:0][COORD_BITS-1:0] shift_q;
  logic                                wr_en;
  cfg_reg_e                            reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = cfg_reg_e'(paddr[APB_ADDR_BITS-1:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        row_q[i]   <= ROW_BITS'(COEFF_ONE) << (COEFF_BITS * i);
        shift_q[i] <= '0;
      end
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_ROW0:    row_q[0]   <= pwdata[ROW_BITS-1:0];
        REG_ROW1:    row_q[1]   <= pwdata[ROW_BITS-1:0];
        REG_ROW2:    row_q[2]   <= pwdata[ROW_BITS-1:0];
        REG_SHIFT_X: shift_q[0] <= pwdata[COORD_BITS-1:0];
        REG_SHIFT_Y: shift_q[1] <= pwdata[COORD_BITS-1:0];
        REG_SHIFT_Z: shift_q[2] <= pwdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_ROW0:    prdata = APB_DATA_BITS'(row_q[0]);
      REG_ROW1:    prdata = APB_DATA_BITS'(row_q[1]);
      REG_ROW2:    prdata = APB_DATA_BITS'(row_q[2]);
      REG_SHIFT_X: prdata = APB_DATA_BITS'(shift_q[0]);
      REG_SHIFT_Y: prdata = APB_DATA_BITS'(shift_q[1]);
      REG_SHIFT_Z: prdata = APB_DATA_BITS'(shift_q[2]);
      default:     prdata = '0;
    endcase
  end

  assign cfg_o.row   = row_q;
  assign cfg_o.shift = shift_q;

endmodule

/* sv/apt_prep.sv */
module apt_prep
  import apt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  point_in_t item_i,
  input  cfg_t      cfg_i,
  output stage1_t   s1_o
);

  logic signed [COORD_BITS-1:0]      pt [NUM_AXES];
  logic [NUM_AXES-1:0][VEC_BITS-1:0] vec_d;
  logic [NUM_AXES-1:0][VEC_BITS-1:0] vec_q;
  logic                              inv_q;
  logic                              valid_q;

  assign pt[0] = item_i.point_x;
  assign pt[1] = item_i.point_y;
  assign pt[2] = item_i.point_z;

  // inverse mode removes the translation first, at full width
  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      if (item_i.action) begin
        vec_d[k] = VEC_BITS'(pt[k]) - VEC_BITS'($signed(cfg_i.shift[k]));
      end else begin
        vec_d[k] = VEC_BITS'(pt[k]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      vec_q <= vec_d;
      inv_q <= item_i.action;
    end
  end

  assign s1_o.valid   = valid_q;
  assign s1_o.inverse = inv_q;
  assign s1_o.vec     = vec_q;

endmodule

/* sv/apt_mult_sum.sv */
module apt_mult_sum
  import apt_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  stage1_t s1_i,
  input  cfg_t    cfg_i,
  output stage3_t s3_o
);

  localparam logic signed [ACC_BITS-1:0] RND_HALF = ACC_BITS'(1) << (FRAC_BITS - 1);

  logic signed [PROD_BITS-1:0]       prod_d [NUM_AXES][NUM_AXES];
  logic signed [PROD_BITS-1:0]       prod_q [NUM_AXES][NUM_AXES];
  logic                              valid2_q;
  logic                              inv2_q;
  logic [NUM_AXES-1:0][ACC_BITS-1:0] acc_d;
  logic [NUM_AXES-1:0][ACC_BITS-1:0] acc_q;
  logic                              valid3_q;
  logic                              inv3_q;

  // forward uses column r of the matrix, inverse uses row r (transpose)
  always_comb begin
    for (int r = 0; r < NUM_AXES; r++) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        if (s1_i.inverse) begin
          prod_d[r][k] = coeff(cfg_i.row, r, k) * $signed(s1_i.vec[k]);
        end else begin
          prod_d[r][k] = coeff(cfg_i.row, k, r) * $signed(s1_i.vec[k]);
        end
      end
    end
  end

  always_comb begin
    for (int r = 0; r < NUM_AXES; r++) begin
      acc_d[r] = ACC_BITS'(prod_q[r][0]) + ACC_BITS'(prod_q[r][1])
               + ACC_BITS'(prod_q[r][2]) + RND_HALF;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid2_q <= 1'b0;
      valid3_q <= 1'b0;
    end else begin
      valid2_q <= s1_i.valid;
      valid3_q <= valid2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_i.valid) begin
      prod_q <= prod_d;
      inv2_q <= s1_i.inverse;
    end
    if (valid2_q) begin
      acc_q  <= acc_d;
      inv3_q <= inv2_q;
    end
  end

  assign s3_o.valid   = valid3_q;
  assign s3_o.inverse = inv3_q;
  assign s3_o.acc     = acc_q;

endmodule

/* sv/apt_round_sat.sv */
module apt_round_sat
  import apt_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  stage3_t s3_i,
  input  cfg_t    cfg_i,
  output logic    done_o,
  output result_t result_o
);

  localparam logic signed [RES_BITS-1:0] SAT_HI = RES_BITS'(COORD_MAX);
  localparam logic signed [RES_BITS-1:0] SAT_LO = RES_BITS'(COORD_MIN);

  logic signed [ACC_BITS-1:0]   shifted [NUM_AXES];
  logic signed [RES_BITS-1:0]   sum     [NUM_AXES];
  logic signed [COORD_BITS-1:0] clamped [NUM_AXES];
  logic [NUM_AXES-1:0]          clip;
  logic                         done_q;
  result_t                      result_q;

  always_comb begin
    for (int r = 0; r < NUM_AXES; r++) begin
      // arithmetic shift gives floor after the half was added
      shifted[r] = $signed(s3_i.acc[r]) >>> FRAC_BITS;
      if (s3_i.inverse) begin
        sum[r] = RES_BITS'(shifted[r]);
      end else begin
        sum[r] = RES_BITS'(shifted[r]) + RES_BITS'($signed(cfg_i.shift[r]));
      end
      priority if (sum[r] > SAT_HI) begin
        clamped[r] = COORD_MAX;
        clip[r]    = 1'b1;
      end else if (sum[r] < SAT_LO) begin
        clamped[r] = COORD_MIN;
        clip[r]    = 1'b1;
      end else begin
        clamped[r] = sum[r][COORD_BITS-1:0];
        clip[r]    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s3_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_i.valid) begin
      result_q.out_x     <= clamped[0];
      result_q.out_y     <= clamped[1];
      result_q.out_z     <= clamped[2];
      result_q.saturated <= |clip;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

/* sv/affine_point_transform.sv */
// Affine point transform: one 3D point in, one transformed point out.
//
// Input channel: an item (action, point_x/y/z) transfers at a rising edge
// with start high and busy low. busy stays low, so a point can be issued
// every cycle.
// Result channel: done_o is high for one cycle with result_o valid; the
// receiver must take it then. Results come back in issue order.
// Pipeline: an accepted point passes through operand prep, 9 parallel
// products, 3-term sums with rounding and shift/translate/clamp, each
// registered, on its way to done_o. Throughput: 1 point per cycle, set by
// the fully pipelined multiplier array.
// Config: APB port, 64-bit data, register i at byte address 8*i (three
// coefficient rows, then x/y/z translation). Write only while no point is
// in flight. pready is always high.
// Reset: matrix goes to identity, translation to zero, pipeline emptied.
// The result register holds its last value between strobes.
module affine_point_transform
  import apt_pkg::*;
#(
  parameter int COEFF_FRAC_BITS = 14
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  point_in_t                item_i,
  output logic                     done_o,
  output result_t                  result_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  cfg_t    cfg;
  stage1_t s1;
  stage3_t s3;
  logic    accept;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  apt_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  apt_prep u_prep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item_i),
    .cfg_i    (cfg),
    .s1_o     (s1)
  );

  apt_mult_sum #(
    .FRAC_BITS (COEFF_FRAC_BITS)
  ) u_mult_sum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .s1_i   (s1),
    .cfg_i  (cfg),
    .s3_o   (s3)
  );

  apt_round_sat #(
    .FRAC_BITS (COEFF_FRAC_BITS)
  ) u_round_sat (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s3_i     (s3),
    .cfg_i    (cfg),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

/* sv/apt_checker.sv */
module apt_checker
  import apt_pkg::*;
(
  input logic    clk_i,
  input logic    rst_ni,
  input logic    start,
  input logic    busy,
  input logic    done_i,
  input result_t result_i
);

  logic accept;
  assign accept = start & ~busy;

  // every transfer in yields a strobe
  a_accept_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##4 done_i)
    else $error("apt: accepted point produced no result");

  // no strobe without a matching transfer in
  a_done_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> $past(accept && rst_ni, 4))
    else $error("apt: result without a matching input");

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("apt: busy raised by a fully pipelined block");

  // a clamped result has at least one coordinate at a range end
  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_i && result_i.saturated) |->
      (result_i.out_x == COORD_MAX || result_i.out_x == COORD_MIN ||
       result_i.out_y == COORD_MAX || result_i.out_y == COORD_MIN ||
       result_i.out_z == COORD_MAX || result_i.out_z == COORD_MIN))
    else $error("apt: saturated flag without a clamped coordinate");

endmodule

bind affine_point_transform apt_checker u_apt_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_i   (done_o),
  .result_i (result_o)
);

/* verif/tb_top.sv */
module tb_top
  import apt_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS      = 14;
  localparam int NUM_ITEMS      = 1350;
  localparam int NUM_PHASES     = 8;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_REPORTS    = 10;
  // addresses past the last register; writes there must be dropped
  localparam int unsigned SPARE_REG_A = NUM_REGS;
  localparam int unsigned SPARE_REG_B = NUM_REGS + 1;

  typedef enum logic {ACT_FORWARD = 1'b0, ACT_INVERSE = 1'b1} action_e;
  typedef enum int {STYLE_IDENTITY, STYLE_RANDOM, STYLE_GENTLE, STYLE_EXTREME} cfg_style_e;

  typedef struct {
    bit          is_cfg;
    int unsigned reg_idx;
    logic [63:0] value;
    point_in_t   pt;
    bit          typed;
    result_t     want;
  } stim_row_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start;
  logic                     busy;
  point_in_t                item_i;
  logic                     done_o;
  result_t                  result_o;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  affine_point_transform #(
    .COEFF_FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item_i),
    .done_o  (done_o),
    .result_o(result_o),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow of the matrix and translation registers
  logic [ROW_BITS-1:0]   coef_row [NUM_AXES];
  logic [COORD_BITS-1:0] offset   [NUM_AXES];

  result_t   predicted_pts [$];
  stim_row_t directed_rows [$];

  int failures;
  int cycles = 0;
  int n_checked;
  int n_forward;
  int n_inverse;
  int n_clamped;
  int n_settings;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic void note_failure(string msg);
    failures++;
    if (failures <= MAX_REPORTS) $display("ERROR: %s", msg);
  endfunction

  function automatic longint coef_at(int i, int j);
    return longint'($signed(coef_row[i][COEFF_BITS*j +: COEFF_BITS]));
  endfunction

  // round half up, floor semantics on negatives
  function automatic longint round_frac(longint v);
    return (v + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp_coord(input longint v, inout bit clipped);
    if (v > longint'(COORD_MAX)) begin
      clipped = 1'b1;
      return COORD_MAX;
    end
    if (v < longint'(COORD_MIN)) begin
      clipped = 1'b1;
      return COORD_MIN;
    end
    return v[COORD_BITS-1:0];
  endfunction

  function automatic result_t transform_point(point_in_t pt);
    longint                pin [NUM_AXES];
    longint                diff [NUM_AXES];
    longint                acc;
    logic [COORD_BITS-1:0] o [NUM_AXES];
    bit                    clipped;
    result_t               res;
    clipped = 1'b0;
    pin[0] = longint'($signed(pt.point_x));
    pin[1] = longint'($signed(pt.point_y));
    pin[2] = longint'($signed(pt.point_z));
    if (pt.action == ACT_INVERSE) begin
      // transpose of the 3x3 part applied to the untranslated point
      for (int i = 0; i < NUM_AXES; i++) diff[i] = pin[i] - longint'($signed(offset[i]));
      for (int i = 0; i < NUM_AXES; i++) begin
        acc = 0;
        for (int j = 0; j < NUM_AXES; j++) acc += coef_at(i, j) * diff[j];
        o[i] = clamp_coord(round_frac(acc), clipped);
      end
    end else begin
      for (int j = 0; j < NUM_AXES; j++) begin
        acc = 0;
        for (int i = 0; i < NUM_AXES; i++) acc += coef_at(i, j) * pin[i];
        o[j] = clamp_coord(round_frac(acc) + longint'($signed(offset[j])), clipped);
      end
    end
    res.out_x     = o[0];
    res.out_y     = o[1];
    res.out_z     = o[2];
    res.saturated = clipped;
    return res;
  endfunction

  function automatic stim_row_t cfg_row(int unsigned idx, logic [63:0] value);
    stim_row_t r;
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.value   = value;
    r.pt      = '0;
    r.typed   = 1'b0;
    r.want    = '0;
    return r;
  endfunction

  function automatic stim_row_t pt_row(action_e a, int x, int y, int z);
    stim_row_t r;
    r.is_cfg     = 1'b0;
    r.reg_idx    = 0;
    r.value      = '0;
    r.pt.action  = a;
    r.pt.point_x = x[COORD_BITS-1:0];
    r.pt.point_y = y[COORD_BITS-1:0];
    r.pt.point_z = z[COORD_BITS-1:0];
    r.typed      = 1'b0;
    r.want       = '0;
    return r;
  endfunction

  function automatic stim_row_t known_row(action_e a, int x, int y, int z,
                                          int ox, int oy, int oz, bit sat);
    stim_row_t r;
    r = pt_row(a, x, y, z);
    r.typed          = 1'b1;
    r.want.out_x     = ox[COORD_BITS-1:0];
    r.want.out_y     = oy[COORD_BITS-1:0];
    r.want.out_z     = oz[COORD_BITS-1:0];
    r.want.saturated = sat;
    return r;
  endfunction

  // result checker: the receiver cannot stall, every strobe is a transfer
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && done_o) begin
      if (predicted_pts.size() == 0) begin
        note_failure($sformatf("result with nothing pending: %0d %0d %0d sat %0b",
                               result_o.out_x, result_o.out_y, result_o.out_z,
                               result_o.saturated));
      end else begin
        want = predicted_pts.pop_front();
        n_checked++;
        if (result_o.saturated) n_clamped++;
        if (result_o !== want)
          note_failure($sformatf("point %0d: expected %0d %0d %0d sat %0b, got %0d %0d %0d sat %0b",
                                 n_checked, want.out_x, want.out_y, want.out_z, want.saturated,
                                 result_o.out_x, result_o.out_y, result_o.out_z,
                                 result_o.saturated));
      end
    end
  end

  // entered and left on a rising edge
  task automatic send_point(point_in_t pt, bit typed, result_t want, int idle_pct);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < idle_pct);
    end
    start  <= 1'b1;
    item_i <= pt;
    do @(posedge clk_i); while (busy);
    predicted_pts.push_back(typed ? want : transform_point(pt));
    if (pt.action == ACT_INVERSE) n_inverse++;
    else n_forward++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (predicted_pts.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_write(int unsigned idx, logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_BITS'(idx * 8);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx < REG_SHIFT_X) coef_row[idx] = value[ROW_BITS-1:0];
    else if (idx < NUM_REGS) offset[idx - REG_SHIFT_X] = value[COORD_BITS-1:0];
    @(posedge clk_i);
  endtask

  task automatic check_readback();
    logic [63:0] got;
    for (int unsigned idx = REG_ROW0; idx <= REG_SHIFT_Z; idx++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= APB_ADDR_BITS'(idx * 8);
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      got      = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (idx < REG_SHIFT_X) begin
        if (got[ROW_BITS-1:0] !== coef_row[idx])
          note_failure($sformatf("reg %0d read %h, expected %h", idx, got[ROW_BITS-1:0],
                                 coef_row[idx]));
      end else if (got[COORD_BITS-1:0] !== offset[idx - REG_SHIFT_X]) begin
        note_failure($sformatf("reg %0d read %h, expected %h", idx, got[COORD_BITS-1:0],
                               offset[idx - REG_SHIFT_X]));
      end
      @(posedge clk_i);
    end
  endtask

  function automatic logic [COEFF_BITS-1:0] pick_coeff(cfg_style_e style, bit diag);
    case (style)
      STYLE_IDENTITY: return diag ? COEFF_ONE : '0;
      STYLE_RANDOM:   return COEFF_BITS'($urandom);
      STYLE_GENTLE:   return COEFF_BITS'($urandom_range(0, 16384) - 8192);
      default: begin
        case ($urandom_range(0, 4))
          0:       return 16'h8000;
          1:       return 16'h7fff;
          2:       return '0;
          3:       return COEFF_ONE;
          default: return -COEFF_ONE;
        endcase
      end
    endcase
  endfunction

  function automatic logic [COORD_BITS-1:0] pick_shift(cfg_style_e style);
    case (style)
      STYLE_RANDOM:  return COORD_BITS'($urandom);
      STYLE_EXTREME: begin
        case ($urandom_range(0, 2))
          0:       return COORD_MIN;
          1:       return COORD_MAX;
          default: return '0;
        endcase
      end
      default:       return COORD_BITS'($urandom_range(0, 8191) - 4096);
    endcase
  endfunction

  task automatic load_matrix(cfg_style_e style);
    logic [ROW_BITS-1:0] row;
    logic [63:0]         junk;
    for (int i = 0; i < NUM_AXES; i++) begin
      for (int j = 0; j < NUM_AXES; j++) row[COEFF_BITS*j +: COEFF_BITS] = pick_coeff(style, i == j);
      junk = {$urandom, $urandom};
      apb_write(REG_ROW0 + i, {junk[63:ROW_BITS], row});
    end
    for (int i = 0; i < NUM_AXES; i++) begin
      // upper bits are don't-care and get random junk
      junk = {$urandom, $urandom};
      apb_write(REG_SHIFT_X + i, {junk[63:COORD_BITS], pick_shift(style)});
    end
    n_settings++;
  endtask

  function automatic logic [COORD_BITS-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0, 1: begin
        case ($urandom_range(0, 4))
          0:       return COORD_MIN;
          1:       return COORD_MAX;
          2:       return '0;
          3:       return '1;
          default: return COORD_BITS'(1);
        endcase
      end
      2, 3, 4, 5: return COORD_BITS'($urandom_range(0, 8191) - 4096);
      default:    return COORD_BITS'($urandom);
    endcase
  endfunction

  function automatic point_in_t rand_point();
    point_in_t pt;
    pt.action  = $urandom_range(0, 1) ? ACT_INVERSE : ACT_FORWARD;
    pt.point_x = rand_coord();
    pt.point_y = rand_coord();
    pt.point_z = rand_coord();
    return pt;
  endfunction

  initial begin
    int      idle_pct [NUM_PHASES];
    int      per_phase;
    int      count;
    int      cmax;
    int      cmin;
    result_t none;
    failures   = 0;
    n_checked  = 0;
    n_forward  = 0;
    n_inverse  = 0;
    n_clamped  = 0;
    n_settings = 1;
    rst_ni     = 1'b0;
    start      = 1'b0;
    item_i     = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    none       = '0;
    cmax       = COORD_MAX;
    cmin       = COORD_MIN;
    idle_pct   = '{0, 63, 19, 0, 63, 19, 63, 0};
    coef_row[0] = ROW_BITS'(COEFF_ONE);
    coef_row[1] = ROW_BITS'(COEFF_ONE) << COEFF_BITS;
    coef_row[2] = ROW_BITS'(COEFF_ONE) << (2 * COEFF_BITS);
    for (int i = 0; i < NUM_AXES; i++) offset[i] = '0;

    directed_rows = {
      // identity after reset: every point passes through
      known_row(ACT_FORWARD, 0, 0, 0, 0, 0, 0, 1'b0),
      known_row(ACT_FORWARD, cmax, cmax, cmax, cmax, cmax, cmax, 1'b0),
      known_row(ACT_FORWARD, cmin, cmin, cmin, cmin, cmin, cmin, 1'b0),
      known_row(ACT_INVERSE, cmax, cmin, 1, cmax, cmin, 1, 1'b0),
      known_row(ACT_INVERSE, -1, -1, -1, -1, -1, -1, 1'b0),
      pt_row(ACT_FORWARD, 1, -1, 24'h555555),
      // extreme translation; shift_y carries junk above bit 23
      cfg_row(REG_SHIFT_X, 64'h0000_0000_007f_ffff),
      cfg_row(REG_SHIFT_Y, 64'hffff_ffff_ff80_0000),
      cfg_row(REG_SHIFT_Z, 64'h1),
      known_row(ACT_FORWARD, cmax, cmin, 0, cmax, cmin, 1, 1'b1),
      known_row(ACT_FORWARD, 0, 0, 0, cmax, cmin, 1, 1'b0),
      known_row(ACT_INVERSE, cmax, cmin, 1, 0, 0, 0, 1'b0),
      known_row(ACT_INVERSE, cmin, cmax, 0, cmin, cmax, -1, 1'b1),
      cfg_row(SPARE_REG_A, '1),
      cfg_row(SPARE_REG_B, '1),
      cfg_row(REG_SHIFT_X, '0),
      cfg_row(REG_SHIFT_Y, '0),
      cfg_row(REG_SHIFT_Z, '0),
      cfg_row(REG_ROW0, 64'h0000_8000_8000_8000),
      cfg_row(REG_ROW1, 64'h0000_7fff_7fff_7fff),
      cfg_row(REG_ROW2, 64'hffff_0001_0001_0001),
      // row 2 is one LSB: rounding ties and just below
      known_row(ACT_FORWARD, 0, 0, 8192, 1, 1, 1, 1'b0),
      known_row(ACT_FORWARD, 0, 0, 8191, 0, 0, 0, 1'b0),
      known_row(ACT_FORWARD, 0, 0, -8192, 0, 0, 0, 1'b0),
      known_row(ACT_FORWARD, 0, 0, -8193, -1, -1, -1, 1'b0),
      pt_row(ACT_FORWARD, cmin, cmin, cmin),
      pt_row(ACT_INVERSE, cmax, cmax, cmax),
      pt_row(ACT_FORWARD, cmax, 0, cmin),
      pt_row(ACT_INVERSE, cmin, 1, cmax)
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[k]) begin
      if (directed_rows[k].is_cfg) begin
        drain();
        apb_write(directed_rows[k].reg_idx, directed_rows[k].value);
      end else begin
        send_point(directed_rows[k].pt, directed_rows[k].typed, directed_rows[k].want, 0);
      end
    end
    n_settings += 2;

    per_phase = NUM_ITEMS / NUM_PHASES;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      load_matrix(cfg_style_e'(ph % 4));
      check_readback();
      count = (ph == NUM_PHASES - 1) ? NUM_ITEMS - per_phase * (NUM_PHASES - 1) : per_phase;
      for (int n = 0; n < count; n++) send_point(rand_point(), 1'b0, none, idle_pct[ph]);
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (predicted_pts.size() != 0)
      note_failure($sformatf("%0d results never arrived", predicted_pts.size()));
    if (failures > MAX_REPORTS) $display("%0d further mismatches not shown", failures - MAX_REPORTS);

    $display("Checked %0d points (%0d forward, %0d inverse), %0d of them clamped,",
             n_checked, n_forward, n_inverse, n_clamped);
    $display("under %0d matrix/translation settings incl. identity and extremes", n_settings);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
sv/apt_pkg.sv
sv/apt_cfg_regs.sv
sv/apt_prep.sv
sv/apt_mult_sum.sv
sv/apt_round_sat.sv
sv/affine_point_transform.sv
sv/apt_checker.sv
verif/tb_top.sv
